### design/mstp_rx_pkg.sv
// ---------------------------------------------------------------------------
// mstp_rx_pkg
// Shared widths, codes and CRC step functions for the MS/TP frame receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package mstp_rx_pkg;

  localparam int unsigned MAX_DATA   = 512;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned OUT_DATA_W = 64;

  localparam logic [7:0]  PREAMBLE_1   = 8'h55;
  localparam logic [7:0]  PREAMBLE_2   = 8'hFF;
  localparam logic [7:0]  BROADCAST    = 8'hFF;
  localparam logic [7:0]  HCRC_INIT    = 8'hFF;
  localparam logic [7:0]  HCRC_RESIDUE = 8'h55;
  localparam logic [15:0] DCRC_INIT    = 16'hFFFF;
  localparam logic [15:0] DCRC_RESIDUE = 16'hF0B8;

  localparam logic [7:0]  RST_STATION  = 8'd0;
  localparam logic [9:0]  RST_MAX_LEN  = 10'd501;
  localparam logic [7:0]  RST_ABORT    = 8'd30;

  // event codes on the input side
  localparam logic [1:0] ACT_OCTET = 2'd0;
  localparam logic [1:0] ACT_ERROR = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_VALID   = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;

  // invalid frame causes
  localparam logic [2:0] CAUSE_TIMEOUT  = 3'd0;
  localparam logic [2:0] CAUSE_LINE     = 3'd1;
  localparam logic [2:0] CAUSE_HDR_CRC  = 3'd2;
  localparam logic [2:0] CAUSE_TOO_LONG = 3'd3;
  localparam logic [2:0] CAUSE_DATA_CRC = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_STATION = 2'd0;
  localparam logic [1:0] REG_MAX_LEN = 2'd1;
  localparam logic [1:0] REG_ABORT   = 2'd2;

  // header crc-8, one octet per call
  function automatic logic [7:0] crc8_step(input logic [7:0] data, input logic [7:0] crc);
    logic [15:0] c;
    c = {8'd0, crc ^ data};
    c = c ^ (c << 1) ^ (c << 2) ^ (c << 3) ^ (c << 4) ^ (c << 5) ^ (c << 6) ^ (c << 7);
    return {c[7:1], c[8]};
  endfunction

  // reflected ccitt crc-16, one octet per call
  function automatic logic [15:0] crc16_step(input logic [7:0] data, input logic [15:0] crc);
    logic [19:0] lo;
    logic [19:0] r;
    lo = {12'd0, crc[7:0] ^ data};
    r  = {12'd0, crc[15:8]} ^ (lo << 8) ^ (lo << 3) ^ (lo << 12) ^ (lo >> 4)
       ^ {16'd0, lo[3:0]} ^ ({16'd0, lo[3:0]} << 7);
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

### design/mstp_frame_receiver.sv
// ---------------------------------------------------------------------------
// mstp_frame_receiver
// MS/TP receive state machine: preamble, header, data field and CRC checks.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one UART event per beat, in_tuser = action (octet, line error,
//           silence tick), in_tdata = received octet.
//   out_* : at most one result per input beat: a data octet with its index,
//           a valid frame addressed to this station or broadcast, or an
//           invalid frame with its cause. Header fields ride along.
//   cfg_* : register writes (station address, max data length, abort ticks),
//           always ready, to be done while no frame is in progress.
// Timing: a result is registered into out_tdata/out_tuser in the cycle after the
//   input beat that caused it. Throughput: one input beat per cycle while in_tready
//   is high, set by the single CRC/state update between the state registers and
//   the output register.
// Stalls: in_tready drops only while a held result is not taken; a new beat
//   is accepted in the same cycle the held result leaves.
// Reset: rst_n low returns to idle with CRCs preset, header fields, silence
//   counter cleared and registers at their defaults; no result is pending.
// ---------------------------------------------------------------------------
`default_nettype none

module mstp_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] octet
  input  wire logic [1:0]  in_tuser,   // [1:0] action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] error_cause, [11:3] data_index, [19:12] data_octet, [27:20] frame_type,
  // [35:28] destination, [43:36] source, [59:44] data_length, [63:60] zero
  output logic [63:0]      out_tdata,
  output logic [1:0]       out_tuser,  // [1:0] kind
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_PREAMBLE = 2'd1;
  localparam logic [1:0] PH_HEADER   = 2'd2;
  localparam logic [1:0] PH_DATA     = 2'd3;

  localparam logic [15:0] MAX_DATA_LEN = 16'(mstp_rx_pkg::MAX_DATA);
  localparam logic [mstp_rx_pkg::IDX_W-1:0] HDR_LAST =
    mstp_rx_pkg::IDX_W'(5);

  // configuration
  logic [7:0] station_r;
  logic [9:0] max_len_r;
  logic [7:0] abort_r;

  // receive state
  logic [1:0]                      phase_r, phase_nxt;
  logic [mstp_rx_pkg::IDX_W-1:0]   fidx_r, fidx_nxt;
  logic [7:0]                      hcrc_r, hcrc_nxt;
  logic [15:0]                     dcrc_r, dcrc_nxt;
  logic [7:0]                      ftype_r, ftype_nxt;
  logic [7:0]                      dest_r, dest_nxt;
  logic [7:0]                      src_r, src_nxt;
  logic [15:0]                     len_r, len_nxt;
  logic [7:0]                      sil_r, sil_nxt;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [63:0] out_data_r;

  logic        in_fire;
  logic        emit;
  logic [1:0]  kind;
  logic [2:0]  cause;
  logic [8:0]  didx;
  logic [7:0]  doct;
  logic [7:0]  oct;
  logic [1:0]  action;
  logic [7:0]  hcrc_upd;
  logic [15:0] dcrc_upd;
  logic [7:0]  sil_inc;
  logic        for_us;
  logic [15:0] fidx_ext;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  assign oct      = in_tdata;
  assign action   = in_tuser;
  assign hcrc_upd = mstp_rx_pkg::crc8_step(oct, hcrc_r);
  assign dcrc_upd = mstp_rx_pkg::crc16_step(oct, dcrc_r);
  assign sil_inc  = (sil_r == 8'hFF) ? sil_r : sil_r + 8'd1;
  assign for_us   = (dest_r == station_r) || (dest_r == mstp_rx_pkg::BROADCAST);
  assign fidx_ext = {{(16 - mstp_rx_pkg::IDX_W){1'b0}}, fidx_r};

  always_comb begin
    phase_nxt = phase_r;
    fidx_nxt  = fidx_r;
    hcrc_nxt  = hcrc_r;
    dcrc_nxt  = dcrc_r;
    ftype_nxt = ftype_r;
    dest_nxt  = dest_r;
    src_nxt   = src_r;
    len_nxt   = len_r;
    sil_nxt   = sil_r;
    emit      = 1'b0;
    kind      = mstp_rx_pkg::KIND_DATA;
    cause     = mstp_rx_pkg::CAUSE_TIMEOUT;
    didx      = 9'd0;
    doct      = 8'd0;
    case (action)
      mstp_rx_pkg::ACT_TICK: begin
        sil_nxt = sil_inc;
        if (phase_r != PH_IDLE && sil_inc >= abort_r) begin
          phase_nxt = PH_IDLE;
          if (phase_r != PH_PREAMBLE) begin
            emit = 1'b1;
            kind = mstp_rx_pkg::KIND_INVALID;
          end
        end
      end
      mstp_rx_pkg::ACT_ERROR: begin
        sil_nxt   = 8'd0;
        phase_nxt = PH_IDLE;
        if (phase_r == PH_HEADER || phase_r == PH_DATA) begin
          emit  = 1'b1;
          kind  = mstp_rx_pkg::KIND_INVALID;
          cause = mstp_rx_pkg::CAUSE_LINE;
        end
      end
      mstp_rx_pkg::ACT_OCTET: begin
        sil_nxt = 8'd0;
        unique case (phase_r)
          PH_IDLE: begin
            if (oct == mstp_rx_pkg::PREAMBLE_1) phase_nxt = PH_PREAMBLE;
          end
          PH_PREAMBLE: begin
            if (oct == mstp_rx_pkg::PREAMBLE_2) begin
              fidx_nxt  = '0;
              hcrc_nxt  = mstp_rx_pkg::HCRC_INIT;
              phase_nxt = PH_HEADER;
            end else if (oct != mstp_rx_pkg::PREAMBLE_1) begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_HEADER: begin
            hcrc_nxt = hcrc_upd;
            fidx_nxt = fidx_r + 1'b1;
            case (fidx_r)
              10'd0:   ftype_nxt = oct;
              10'd1:   dest_nxt  = oct;
              10'd2:   src_nxt   = oct;
              10'd3:   len_nxt   = {oct, 8'd0};
              10'd4:   len_nxt   = {len_r[15:8], oct};
              default: begin
                // header crc octet: check and decide
                fidx_nxt  = fidx_r;
                phase_nxt = PH_IDLE;
                if (hcrc_upd != mstp_rx_pkg::HCRC_RESIDUE) begin
                  emit  = 1'b1;
                  kind  = mstp_rx_pkg::KIND_INVALID;
                  cause = mstp_rx_pkg::CAUSE_HDR_CRC;
                end else if (len_r == 16'd0) begin
                  emit = for_us;
                  kind = mstp_rx_pkg::KIND_VALID;
                end else if (len_r > {6'd0, max_len_r} || len_r > MAX_DATA_LEN) begin
                  emit  = 1'b1;
                  kind  = mstp_rx_pkg::KIND_INVALID;
                  cause = mstp_rx_pkg::CAUSE_TOO_LONG;
                end else begin
                  fidx_nxt  = '0;
                  dcrc_nxt  = mstp_rx_pkg::DCRC_INIT;
                  phase_nxt = PH_DATA;
                end
              end
            endcase
          end
          PH_DATA: begin
            dcrc_nxt = dcrc_upd;
            if (fidx_ext < len_r) begin
              fidx_nxt = fidx_r + 1'b1;
              emit     = 1'b1;
              kind     = mstp_rx_pkg::KIND_DATA;
              didx     = fidx_r[8:0];
              doct     = oct;
            end else if (fidx_ext == len_r) begin
              fidx_nxt = fidx_r + 1'b1;
            end else begin
              phase_nxt = PH_IDLE;
              if (dcrc_upd != mstp_rx_pkg::DCRC_RESIDUE) begin
                emit  = 1'b1;
                kind  = mstp_rx_pkg::KIND_INVALID;
                cause = mstp_rx_pkg::CAUSE_DATA_CRC;
              end else begin
                emit = for_us;
                kind = mstp_rx_pkg::KIND_VALID;
              end
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= mstp_rx_pkg::RST_STATION;
      max_len_r <= mstp_rx_pkg::RST_MAX_LEN;
      abort_r   <= mstp_rx_pkg::RST_ABORT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mstp_rx_pkg::REG_STATION: station_r <= cfg_data[7:0];
        mstp_rx_pkg::REG_MAX_LEN: max_len_r <= cfg_data;
        mstp_rx_pkg::REG_ABORT:   abort_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      fidx_r  <= '0;
      hcrc_r  <= mstp_rx_pkg::HCRC_INIT;
      dcrc_r  <= mstp_rx_pkg::DCRC_INIT;
      ftype_r <= 8'd0;
      dest_r  <= 8'd0;
      src_r   <= 8'd0;
      len_r   <= 16'd0;
      sil_r   <= 8'd0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      fidx_r  <= fidx_nxt;
      hcrc_r  <= hcrc_nxt;
      dcrc_r  <= dcrc_nxt;
      ftype_r <= ftype_nxt;
      dest_r  <= dest_nxt;
      src_r   <= src_nxt;
      len_r   <= len_nxt;
      sil_r   <= sil_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // header values as they stand after this beat
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_kind_r <= kind;
      out_data_r <= {4'd0, len_nxt, src_nxt, dest_nxt, ftype_nxt, doct, didx, cause};
    end
  end

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kind_r == mstp_rx_pkg::KIND_DATA ||
                     out_kind_r == mstp_rx_pkg::KIND_VALID ||
                     out_kind_r == mstp_rx_pkg::KIND_INVALID))
    else $error("illegal result kind");

  a_cause_only_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != mstp_rx_pkg::KIND_INVALID) |-> (out_data_r[2:0] == 3'd0))
    else $error("error cause on a non-invalid result");

  a_data_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (len_r != 16'd0 && len_r <= MAX_DATA_LEN &&
                              fidx_ext <= len_r + 16'd1))
    else $error("data phase with out-of-range length or index");

  a_hdr_index: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |-> (fidx_r <= HDR_LAST))
    else $error("header index past crc octet");

  a_data_index_order: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && emit && kind == mstp_rx_pkg::KIND_DATA) |=>
      (out_data_r[11:3] == $past(fidx_r[8:0]) && phase_r == PH_DATA))
    else $error("data beat index mismatch");

endmodule

`default_nettype wire
